// ===== src/wcn_pkg.sv =====
package wcn_pkg;

  localparam int WCN_COORD_FRAC_BITS = 16;
  localparam int JIT_BITS = 24;
  localparam int CELLS = 27;
  localparam int LEAVES = 32;
  localparam int ERR_W = 25;
  localparam int SQ_W = 2 * ERR_W;
  localparam int D2_W = 52;
  localparam int DIST_SHIFT = 16;
  localparam int RAD_W = D2_W - DIST_SHIFT;
  localparam int ROOT_W = RAD_W / 2;

  localparam logic [31:0] MIX_M1 = 32'h7feb352d;
  localparam logic [31:0] MIX_M2 = 32'h846ca68b;
  localparam logic [31:0] SEED_MUL = 32'h9e3779b1;
  localparam logic [31:0] SEED_ADD = 32'h01234567;
  localparam logic [31:0] HASH_X = 32'd73856093;
  localparam logic [31:0] HASH_Y = 32'd19349663;
  localparam logic [31:0] HASH_Z = 32'd83492791;
  localparam logic [31:0] JIT_Y_ADD = 32'h9e3779b1;
  localparam logic [31:0] JIT_Z_ADD = 32'h85ebca6b;
  localparam logic [D2_W-1:0] DIST_MAX = '1;

  // Offset codes for a neighbor cell: minus one, same, plus one
  localparam logic [1:0] OFS_NEG = 2'd0;
  localparam logic [1:0] OFS_ZERO = 2'd1;
  localparam logic [1:0] OFS_POS = 2'd2;

  typedef struct packed {
    logic [D2_W-1:0] f1;
    logic [D2_W-1:0] f2;
    logic [31:0]     hash;
  } best_t;

  function automatic logic [31:0] xorshr(logic [31:0] v, int sh);
    return v ^ (v >> sh);
  endfunction

  // First multiply of the avalanche mix
  function automatic logic [31:0] mix_a(logic [31:0] v);
    return 32'(xorshr(v, 16) * MIX_M1);
  endfunction

  // Second multiply of the avalanche mix
  function automatic logic [31:0] mix_b(logic [31:0] p);
    return 32'(xorshr(p, 15) * MIX_M2);
  endfunction

  // Final fold of the avalanche mix
  function automatic logic [31:0] mix_c(logic [31:0] p);
    return xorshr(p, 16);
  endfunction

  // Magnitude of offset + jitter - fraction, all Q.24
  function automatic logic [ERR_W-1:0] abs_err(logic [23:0] jit, logic [23:0] frac,
                                               logic [1:0] ofs);
    logic [ERR_W:0] e;
    logic [ERR_W:0] n;
    e = {2'b00, jit} - {2'b00, frac};
    if (ofs == OFS_NEG) begin
      e = e - (ERR_W+1)'(1 << JIT_BITS);
    end else if (ofs == OFS_POS) begin
      e = e + (ERR_W+1)'(1 << JIT_BITS);
    end
    n = ~e + 1'b1;
    return e[ERR_W] ? n[ERR_W-1:0] : e[ERR_W-1:0];
  endfunction

  // Merge two groups; a comes earlier in visit order and wins ties
  function automatic best_t merge_best(best_t a, best_t b);
    best_t r;
    if (b.f1 < a.f1) begin
      r.f1 = b.f1;
      r.hash = b.hash;
      r.f2 = (a.f1 < b.f2) ? a.f1 : b.f2;
    end else begin
      r.f1 = a.f1;
      r.hash = a.hash;
      r.f2 = (b.f1 < a.f2) ? b.f1 : a.f2;
    end
    return r;
  endfunction

endpackage

// ===== src/wcn_if.sv =====
interface wcn_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface wcn_result_if;
  logic        valid;
  logic        ready;
  logic [17:0] nearest_distance;
  logic [17:0] second_distance;
  logic [31:0] nearest_cell_hash;

  modport source (output valid, nearest_distance, second_distance, nearest_cell_hash,
                  input ready);
  modport sink (input valid, nearest_distance, second_distance, nearest_cell_hash,
                output ready);
endinterface

// ===== src/worley_cellular_noise_3d_core.sv =====
// 3D cellular noise, nearest and second-nearest feature distance. Points enter on
// the point channel at up to one word per clock; each produces one result word,
// in order. The pipeline holds the hash chain (three cascaded
// avalanche mixes plus the two jitter mixes, one multiply per stage), the squared
// distance stages, a five-level registered compare tree over the 27 cells and an
// 18-stage bit-per-stage square root. A stall on the result channel freezes the
// whole pipeline. The user must write noise_seed through seed_we/seed_wdata only while
// no point is in flight; the block does not enforce this. It resets to zero.
module worley_cellular_noise_3d_core import wcn_pkg::*; #(
  parameter int COORD_FRAC_BITS = WCN_COORD_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                seed_we,
  input  logic [31:0]         seed_wdata,
  wcn_point_if.sink           point,
  wcn_result_if.source        result
);

  localparam int FRAC_SHIFT = JIT_BITS - COORD_FRAC_BITS;
  localparam logic [31:0] FRAC_MASK = 32'((64'd1 << COORD_FRAC_BITS) - 64'd1);
  localparam int PRE_STG = 18;
  localparam int LAT = PRE_STG + ROOT_W;

  logic adv;
  logic [LAT-1:0] vld;
  logic [31:0] seed_acc;

  // Seed premultiplied once per write
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_acc <= SEED_ADD;
    end else if (seed_we) begin
      seed_acc <= 32'(seed_wdata * SEED_MUL) + SEED_ADD;
    end
  end

  // Whole pipeline moves unless the output word is stalled
  assign adv = !vld[LAT-1] || result.ready;
  assign point.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], point.valid};
    end
  end

  // Input register
  logic [31:0] x0, y0, z0;
  always_ff @(posedge clk) begin
    if (adv) begin
      x0 <= point.coord_x;
      y0 <= point.coord_y;
      z0 <= point.coord_z;
    end
  end

  // Floor to cell, fraction to Q.24
  logic [31:0] cx, cy, cz;
  logic [23:0] frx, fry, frz;
  assign cx = 32'($signed(x0) >>> COORD_FRAC_BITS);
  assign cy = 32'($signed(y0) >>> COORD_FRAC_BITS);
  assign cz = 32'($signed(z0) >>> COORD_FRAC_BITS);
  assign frx = 24'(x0 & FRAC_MASK) << FRAC_SHIFT;
  assign fry = 24'(y0 & FRAC_MASK) << FRAC_SHIFT;
  assign frz = 24'(z0 & FRAC_MASK) << FRAC_SHIFT;

  logic [31:0] px [3];
  logic [31:0] py_q [1:3][3];
  logic [31:0] pz_q [1:5][3];
  logic [23:0] fx_q [1:9];
  logic [23:0] fy_q [1:9];
  logic [23:0] fz_q [1:9];

  // Neighbor coordinate products, carry fractions and later products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        px[i] <= 32'((cx + 32'(i) - 32'd1) * HASH_X);
        py_q[1][i] <= 32'((cy + 32'(i) - 32'd1) * HASH_Y);
        pz_q[1][i] <= 32'((cz + 32'(i) - 32'd1) * HASH_Z);
        for (int s = 2; s <= 3; s++) py_q[s][i] <= py_q[s-1][i];
        for (int s = 2; s <= 5; s++) pz_q[s][i] <= pz_q[s-1][i];
      end
      fx_q[1] <= frx;
      fy_q[1] <= fry;
      fz_q[1] <= frz;
      for (int s = 2; s <= 9; s++) begin
        fx_q[s] <= fx_q[s-1];
        fy_q[s] <= fy_q[s-1];
        fz_q[s] <= fz_q[s-1];
      end
    end
  end

  // Hash chain: x level, y level, z level, then jitter mixes
  logic [31:0] m1x [3];
  logic [31:0] m2x [3];
  logic [31:0] m1y [9];
  logic [31:0] m2y [9];
  logic [31:0] m1z [CELLS];
  logic [31:0] m2z [CELLS];
  logic [31:0] h8 [CELLS];
  logic [31:0] h9 [CELLS];
  logic [31:0] ja [CELLS];
  logic [31:0] ka [CELLS];
  logic [31:0] jb [CELLS];
  logic [31:0] kb [CELLS];
  logic [31:0] h10 [CELLS];
  logic [31:0] h11 [CELLS];
  logic [31:0] h12 [CELLS];
  logic [ERR_W-1:0] ax [CELLS];
  logic [ERR_W-1:0] ay [CELLS];
  logic [ERR_W-1:0] az [CELLS];
  logic [SQ_W-1:0] sx [CELLS];
  logic [SQ_W-1:0] sy [CELLS];
  logic [SQ_W-1:0] sz [CELLS];
  logic [D2_W-1:0] d2 [CELLS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m1x[i] <= mix_a(seed_acc ^ px[i]);
        m2x[i] <= mix_b(m1x[i]);
      end
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          m1y[j*3+i] <= mix_a(mix_c(m2x[i]) ^ py_q[3][j]);
          m2y[j*3+i] <= mix_b(m1y[j*3+i]);
        end
      end
    end
  end

  for (genvar n = 0; n < CELLS; n++) begin : g_cell
    localparam int IX = n % 3;
    localparam int IY = (n / 3) % 3;
    localparam int IZ = n / 9;
    localparam int IXY = n % 9;

    always_ff @(posedge clk) begin
      if (adv) begin
        m1z[n] <= mix_a(mix_c(m2y[IXY]) ^ pz_q[5][IZ]);
        m2z[n] <= mix_b(m1z[n]);
        h8[n] <= mix_c(m2z[n]);
        ja[n] <= mix_a(mix_c(m2z[n]) + JIT_Y_ADD);
        ka[n] <= mix_a(mix_c(m2z[n]) + JIT_Z_ADD);
        h9[n] <= h8[n];
        jb[n] <= mix_b(ja[n]);
        kb[n] <= mix_b(ka[n]);
        ax[n] <= abs_err(h9[n][31:8], fx_q[9], 2'(IX));
        ay[n] <= abs_err(24'(mix_c(jb[n]) >> 8), fy_q[9], 2'(IY));
        az[n] <= abs_err(24'(mix_c(kb[n]) >> 8), fz_q[9], 2'(IZ));
        h10[n] <= h9[n];
        sx[n] <= SQ_W'(ax[n]) * SQ_W'(ax[n]);
        sy[n] <= SQ_W'(ay[n]) * SQ_W'(ay[n]);
        sz[n] <= SQ_W'(az[n]) * SQ_W'(az[n]);
        h11[n] <= h10[n];
        d2[n] <= D2_W'(sx[n]) + D2_W'(sy[n]) + D2_W'(sz[n]);
        h12[n] <= h11[n];
      end
    end
  end

  // Leaves in visit order, padded with never-winning entries
  best_t leaf [LEAVES];
  always_comb begin
    for (int n = 0; n < CELLS; n++) begin
      leaf[n] = '{f1: d2[n], f2: DIST_MAX, hash: h12[n]};
    end
    for (int n = CELLS; n < LEAVES; n++) begin
      leaf[n] = '{f1: DIST_MAX, f2: DIST_MAX, hash: '0};
    end
  end

  // Registered merge tree, earlier half always on the left
  best_t lv1 [16];
  best_t lv2 [8];
  best_t lv3 [4];
  best_t lv4 [2];
  best_t lv5;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 16; i++) lv1[i] <= merge_best(leaf[2*i], leaf[2*i+1]);
      for (int i = 0; i < 8; i++) lv2[i] <= merge_best(lv1[2*i], lv1[2*i+1]);
      for (int i = 0; i < 4; i++) lv3[i] <= merge_best(lv2[2*i], lv2[2*i+1]);
      for (int i = 0; i < 2; i++) lv4[i] <= merge_best(lv3[2*i], lv3[2*i+1]);
      lv5 <= merge_best(lv4[0], lv4[1]);
    end
  end

  // Roots of the distances; hash follows alongside
  logic [ROOT_W-1:0] root1, root2;
  logic [31:0] hq [ROOT_W];

  wcn_isqrt #(.RAD_BITS(RAD_W)) u_sqrt_f1 (
    .clk  (clk),
    .en   (adv),
    .rad  (lv5.f1[D2_W-1:DIST_SHIFT]),
    .root (root1)
  );

  wcn_isqrt #(.RAD_BITS(RAD_W)) u_sqrt_f2 (
    .clk  (clk),
    .en   (adv),
    .rad  (lv5.f2[D2_W-1:DIST_SHIFT]),
    .root (root2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      hq[0] <= lv5.hash;
      for (int s = 1; s < ROOT_W; s++) hq[s] <= hq[s-1];
    end
  end

  assign result.valid = vld[LAT-1];
  assign result.nearest_distance = root1;
  assign result.second_distance = root2;
  assign result.nearest_cell_hash = hq[ROOT_W-1];

  // A stalled pipeline holds every valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("valid bits moved during stall");

  // An accepted point lands in the input stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> vld[0])
    else $error("accepted point lost");

  // Tree output keeps nearest no farther than second
  a_tree_order: assert property (@(posedge clk) disable iff (rst)
    vld[PRE_STG-1] |-> lv5.f1 <= lv5.f2)
    else $error("merge tree order broken");

  // Delivered distances are ordered
  a_out_order: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.nearest_distance <= result.second_distance)
    else $error("result distances out of order");

endmodule

// ===== src/wcn_isqrt.sv =====
module wcn_isqrt import wcn_pkg::*; #(
  parameter int RAD_BITS = RAD_W
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [RAD_BITS-1:0]   rad,
  output logic [RAD_BITS/2-1:0] root
);

  localparam int RW = RAD_BITS / 2;
  localparam int MW = RW + 2;

  logic [MW-1:0]       rem_q  [RW];
  logic [RW-1:0]       root_q [RW];
  logic [RAD_BITS-1:0] rad_q  [RW];

  // One result bit per stage, restoring form
  for (genvar s = 0; s < RW; s++) begin : g_step
    logic [MW-1:0]       rem_in;
    logic [RW-1:0]       root_in;
    logic [RAD_BITS-1:0] rad_in;
    logic [MW-1:0]       cur;
    logic [MW-1:0]       test;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign root_in = '0;
      assign rad_in = rad;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in = rad_q[s-1];
    end

    assign cur = {rem_in[MW-3:0], rad_in[RAD_BITS-1 -: 2]};
    assign test = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[s] <= rad_in << 2;
        if (cur >= test) begin
          rem_q[s] <= cur - test;
          root_q[s] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[s] <= cur;
          root_q[s] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import wcn_pkg::*;

  localparam int LATENCY = 36;
  localparam int FRAC_BITS = WCN_COORD_FRAC_BITS;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [17:0] f1_root;
    logic [17:0] f2_root;
    logic [31:0] hash;
  } noise_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seed_we = 1'b0;
  logic [31:0] seed_wdata = '0;

  wcn_point_if point ();
  wcn_result_if result ();

  worley_cellular_noise_3d_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_wdata (seed_wdata),
    .point      (point.sink),
    .result     (result.source)
  );

  logic [31:0] seed_model = '0;
  noise_word_t noise_queue[$];
  int mismatch_count = 0;
  longint cycle_count = 0;
  int hold_off_cycles = 0;
  bit stall_enable = 1'b1;

  always #5 clk = ~clk;

  initial begin
    point.valid = 1'b0;
    point.coord_x = '0;
    point.coord_y = '0;
    point.coord_z = '0;
    result.ready = 1'b0;
  end

  // Stop on a runaway run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] avalanche(logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * 32'h7feb352d;
    v = v ^ (v >> 15);
    v = v * 32'h846ca68b;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic logic [31:0] hash_cell(logic [31:0] cx, logic [31:0] cy,
                                            logic [31:0] cz, logic [31:0] seed);
    logic [31:0] acc;
    acc = seed * 32'h9e3779b1 + 32'h01234567;
    acc = avalanche(acc ^ (cx * 32'd73856093));
    acc = avalanche(acc ^ (cy * 32'd19349663));
    acc = avalanche(acc ^ (cz * 32'd83492791));
    return acc;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic noise_word_t worley_noise(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz, logic [31:0] seed);
    logic [31:0] cell_idx[3];
    longint frac[3];
    logic [31:0] raw[3];
    logic [63:0] best1, best2, d2;
    logic [31:0] best_hash, h;
    longint jit[3];
    longint e;
    int ofs[3];
    noise_word_t w;
    raw[0] = px; raw[1] = py; raw[2] = pz;
    for (int k = 0; k < 3; k++) begin
      cell_idx[k] = 32'($signed(raw[k]) >>> FRAC_BITS);
      frac[k] = longint'(raw[k] & ((32'd1 << FRAC_BITS) - 1)) << (JIT_BITS - FRAC_BITS);
    end
    best1 = '1; best2 = '1; best_hash = '0;
    for (int dz = -1; dz <= 1; dz++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          ofs[0] = dx; ofs[1] = dy; ofs[2] = dz;
          h = hash_cell(cell_idx[0] + 32'(dx), cell_idx[1] + 32'(dy),
                        cell_idx[2] + 32'(dz), seed);
          jit[0] = longint'(h >> 8);
          jit[1] = longint'(avalanche(h + 32'h9e3779b1) >> 8);
          jit[2] = longint'(avalanche(h + 32'h85ebca6b) >> 8);
          d2 = 0;
          for (int k = 0; k < 3; k++) begin
            e = longint'(ofs[k]) * (longint'(1) << JIT_BITS) + jit[k] - frac[k];
            d2 = d2 + 64'(e * e);
          end
          if (d2 < best1) begin
            best2 = best1; best1 = d2; best_hash = h;
          end else if (d2 < best2) begin
            best2 = d2;
          end
        end
    w.f1_root = 18'(int_sqrt(best1) >> 8);
    w.f2_root = 18'(int_sqrt(best2) >> 8);
    w.hash = best_hash;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Drain: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      result.ready <= 1'b0;
    end else if (stall_enable) begin
      result.ready <= ($urandom_range(0, 99) < 70);
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    noise_word_t want;
    if (!rst && result.valid && result.ready) begin
      if (noise_queue.size() == 0) begin
        report_mismatch("unexpected word", result.nearest_cell_hash, '0);
      end else begin
        want = noise_queue.pop_front();
        if (result.nearest_distance !== want.f1_root)
          report_mismatch("nearest_distance", 32'(result.nearest_distance), 32'(want.f1_root));
        if (result.second_distance !== want.f2_root)
          report_mismatch("second_distance", 32'(result.second_distance), 32'(want.f2_root));
        if (result.nearest_cell_hash !== want.hash)
          report_mismatch("nearest_cell_hash", result.nearest_cell_hash, want.hash);
      end
    end
  end

  // Drop valid only across a gap, so back-to-back words keep it high
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int gap;
    gap = 0;
    if (stall_enable) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    end
    if (gap > 0) begin
      point.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point.valid <= 1'b1;
    point.coord_x <= px;
    point.coord_y <= py;
    point.coord_z <= pz;
    noise_queue.push_back(worley_noise(px, py, pz, seed_model));
    @(posedge clk);
    while (!point.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    point.valid <= 1'b0;
    while (noise_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    wait_drained();
    seed_we <= 1'b1;
    seed_wdata <= value;
    @(posedge clk);
    seed_we <= 1'b0;
    seed_model = value;
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: return 32'($urandom_range(0, 3)) << 30 | 32'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] edge_vals[8];
    edge_vals = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff,
                  32'h00010000, 32'hffff0000, 32'h0000ffff, 32'hffff8000};
    for (int k = 0; k < 8; k++)
      send_point(edge_vals[k], edge_vals[(k + 3) % 8], edge_vals[(k + 5) % 8]);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    // Same point twice gives the same answer
    send_point(32'h00018000, 32'hfffe8000, 32'h00000001);
    send_point(32'h00018000, 32'hfffe8000, 32'h00000001);
    send_point(32'h00020000, 32'h0001ffff, 32'h00000000);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++)
      send_point(random_coord(), random_coord(), random_coord());
  endtask

  // Hold the drain off long enough to fill the pipeline and stall input
  task automatic test_backpressure();
    wait_drained();
    hold_off_cycles = 200;
    for (int n = 0; n < 80; n++)
      send_point($urandom(), $urandom(), $urandom());
  endtask

  task automatic test_full_rate(int count);
    stall_enable = 1'b0;
    test_random(count);
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    write_seed(32'hffffffff);
    test_directed();
    test_random(300);
    write_seed(32'h00000001);
    test_backpressure();
    test_full_rate(300);
    write_seed($urandom());
    test_random(400);
    write_seed(32'h00000000);
    test_random(150);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
